FILE: design/output_change_trace_ring_unit_assert.svh
// Assertion macros shared by the trace ring modules.
`ifndef OUTPUT_CHANGE_TRACE_RING_UNIT_ASSERT_SVH
`define OUTPUT_CHANGE_TRACE_RING_UNIT_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define OCTR_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define OCTR_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

FILE: design/octr_pkg.sv
// Types, constants and helpers shared by the trace ring modules.
package octr_pkg;

  localparam int unsigned RingDepth       = 4096;
  localparam int unsigned WatchedCounters = 5;
  localparam int unsigned ValueBits       = 16;
  localparam int unsigned ChannelCount    = (WatchedCounters < 5) ? WatchedCounters : 5;
  localparam int unsigned ChanW           = 3;
  localparam int unsigned QueueDepth      = 4;
  localparam int unsigned PendW           = 13;

  // Channel indexes in scan order
  localparam logic [ChanW-1:0] CH_GYRO   = 3'd0;
  localparam logic [ChanW-1:0] CH_CDU_X  = 3'd1;
  localparam logic [ChanW-1:0] CH_CDU_Y  = 3'd2;
  localparam logic [ChanW-1:0] CH_CDU_Z  = 3'd3;
  localparam logic [ChanW-1:0] CH_THRUST = 3'd4;

  // Counter addresses (octal 047, 050, 051, 052, 055)
  localparam logic [5:0] ADDR_GYRO   = 6'd39;
  localparam logic [5:0] ADDR_CDU_X  = 6'd40;
  localparam logic [5:0] ADDR_CDU_Y  = 6'd41;
  localparam logic [5:0] ADDR_CDU_Z  = 6'd42;
  localparam logic [5:0] ADDR_THRUST = 6'd45;

  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_POP   = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_RESET = 2'd3
  } octr_func_e;

  typedef enum logic [1:0] {
    CMD_PUSH,
    CMD_POP,
    CMD_CLEAR
  } octr_cmd_e;

  typedef enum logic {
    FE_IDLE,
    FE_SCAN
  } octr_fe_state_e;

  typedef enum logic {
    BK_IDLE,
    BK_READ
  } octr_bk_state_e;

  typedef logic [ValueBits-1:0] octr_value_t;

  // Command passed from the front to the back through the queue
  typedef struct packed {
    octr_cmd_e         op;
    logic [ChanW-1:0]  chan;
    octr_value_t       prior;
    octr_value_t       after;
    logic [63:0]       tick;
  } octr_cmd_t;

  // One ring entry
  typedef struct packed {
    logic [63:0]       seq;
    logic [63:0]       tick;
    logic [ChanW-1:0]  chan;
    octr_value_t       prior;
    octr_value_t       after;
  } octr_entry_t;

  // Map a channel index to its counter address
  function automatic logic [5:0] chan_addr(input logic [ChanW-1:0] ch);
    logic [5:0] addr;
    case (ch)
      CH_GYRO:   addr = ADDR_GYRO;
      CH_CDU_X:  addr = ADDR_CDU_X;
      CH_CDU_Y:  addr = ADDR_CDU_Y;
      CH_CDU_Z:  addr = ADDR_CDU_Z;
      CH_THRUST: addr = ADDR_THRUST;
      default:   addr = ADDR_GYRO;
    endcase
    return addr;
  endfunction

endpackage

FILE: design/output_change_trace_ring_unit.sv
// Top level of the output change trace ring.
//
// Usage: drive func_i and the five counter samples with start high; the command
// is taken at a clock edge where start is high and busy is low.
// func 0 is a tick: the first tick after reset or clear records a baseline, later
// ticks log each changed counter (gyro, X, Y, Z, thrust order) as a ring entry.
// func 1 pops the oldest entry; func 2 clears the trace; func 3 also zeroes the
// tick count. Only a pop gives a result: done_o is high for one cycle with the
// entry fields, and the receiver must take it then.
// Timing: a tick after the baseline holds busy while the front scans the five
// watched channels in order, waiting at a changed one while the queue is full;
// each change becomes one ring write in the back end, one write per cycle on
// the single-port ring memory while pushes lead the queue. Pop, clear and reset
// enter the queue in their accept cycle. A pop result, behind earlier queued
// writes, passes the queue, the ring read (unless the ring is empty) and outputs.
// busy also rises while the four-entry command queue is full.
// Reset: asynchronous, active low; the ring is empty, all counters are zero and
// the baseline is re-armed. Ring contents are not cleared, no clearing pass.
module output_change_trace_ring_unit #(
  parameter int unsigned RING_DEPTH = octr_pkg::RingDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         func_i,
  input  logic [15:0]        gyro_count_i,
  input  logic [15:0]        cdu_x_command_i,
  input  logic [15:0]        cdu_y_command_i,
  input  logic [15:0]        cdu_z_command_i,
  input  logic [15:0]        thrust_count_i,
  output logic               done_o,
  output logic               entry_valid_o,
  output logic [63:0]        sequence_number_o,
  output logic [63:0]        tick_number_o,
  output logic [5:0]         ctr_addr_o,
  output logic signed [16:0] change_amount_o,
  output logic [15:0]        prior_value_o,
  output logic [15:0]        new_value_o,
  output logic [12:0]        entries_pending_o,
  output logic [31:0]        dropped_total_o
);
  import octr_pkg::*;

  logic      q_push;
  logic      q_pop;
  logic      q_full;
  logic      q_empty;
  octr_cmd_t q_wdata;
  octr_cmd_t q_rdata;

  // Accept and classify commands
  octr_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start),
    .func_i          (func_i),
    .gyro_count_i    (gyro_count_i),
    .cdu_x_command_i (cdu_x_command_i),
    .cdu_y_command_i (cdu_y_command_i),
    .cdu_z_command_i (cdu_z_command_i),
    .thrust_count_i  (thrust_count_i),
    .full_i          (q_full),
    .busy_o          (busy),
    .push_o          (q_push),
    .cmd_o           (q_wdata)
  );

  // Decouple front and back
  octr_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .empty_o (q_empty),
    .data_o  (q_rdata)
  );

  // Run commands against the ring
  octr_back #(
    .RING_DEPTH (RING_DEPTH)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (q_rdata),
    .empty_i           (q_empty),
    .pop_o             (q_pop),
    .done_o            (done_o),
    .entry_valid_o     (entry_valid_o),
    .sequence_number_o (sequence_number_o),
    .tick_number_o     (tick_number_o),
    .ctr_addr_o        (ctr_addr_o),
    .change_amount_o   (change_amount_o),
    .prior_value_o     (prior_value_o),
    .new_value_o       (new_value_o),
    .entries_pending_o (entries_pending_o),
    .dropped_total_o   (dropped_total_o)
  );

endmodule

FILE: design/octr_front.sv
// Front end: accepts commands, keeps the tick count and baseline, scans for changes.
module octr_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [1:0]          func_i,
  input  logic [15:0]         gyro_count_i,
  input  logic [15:0]         cdu_x_command_i,
  input  logic [15:0]         cdu_y_command_i,
  input  logic [15:0]         cdu_z_command_i,
  input  logic [15:0]         thrust_count_i,
  input  logic                full_i,
  output logic                busy_o,
  output logic                push_o,
  output octr_pkg::octr_cmd_t cmd_o
);
  import octr_pkg::*;

  octr_fe_state_e          state_q, state_d;
  logic [63:0]             tick_q, tick_d;
  logic                    base_q, base_d;
  octr_value_t             last_q   [ChannelCount];
  octr_value_t             last_d   [ChannelCount];
  octr_value_t             before_q [ChannelCount];
  octr_value_t             before_d [ChannelCount];
  octr_value_t             after_q  [ChannelCount];
  octr_value_t             after_d  [ChannelCount];
  logic [ChannelCount-1:0] mask_q, mask_d;
  logic [ChanW-1:0]        idx_q, idx_d;
  octr_value_t             sample   [5];
  logic                    accept;
  logic                    step;

  // Truncate the samples to the value width
  assign sample[0] = ValueBits'(gyro_count_i);
  assign sample[1] = ValueBits'(cdu_x_command_i);
  assign sample[2] = ValueBits'(cdu_y_command_i);
  assign sample[3] = ValueBits'(cdu_z_command_i);
  assign sample[4] = ValueBits'(thrust_count_i);

  assign busy_o = (state_q != FE_IDLE) || full_i;
  assign accept = start_i && !busy_o;

  // Classify the command and walk the channels of a tick
  always_comb begin
    state_d  = state_q;
    tick_d   = tick_q;
    base_d   = base_q;
    last_d   = last_q;
    before_d = before_q;
    after_d  = after_q;
    mask_d   = mask_q;
    idx_d    = idx_q;
    push_o   = 1'b0;
    step     = 1'b0;
    cmd_o        = '0;
    cmd_o.op     = CMD_PUSH;
    cmd_o.chan   = idx_q;
    cmd_o.prior  = before_q[idx_q];
    cmd_o.after  = after_q[idx_q];
    cmd_o.tick   = tick_q;
    case (state_q)
      FE_IDLE: begin
        if (accept) begin
          case (octr_func_e'(func_i))
            FUNC_TICK: begin
              tick_d = tick_q + 64'd1;
              for (int i = 0; i < ChannelCount; i++) begin
                last_d[i]   = sample[i];
                before_d[i] = last_q[i];
                after_d[i]  = sample[i];
                mask_d[i]   = (sample[i] != last_q[i]);
              end
              if (base_q) begin
                idx_d   = '0;
                state_d = FE_SCAN;
              end
              base_d = 1'b1;
            end
            FUNC_POP: begin
              push_o   = 1'b1;
              cmd_o.op = CMD_POP;
            end
            FUNC_CLEAR: begin
              base_d   = 1'b0;
              push_o   = 1'b1;
              cmd_o.op = CMD_CLEAR;
            end
            FUNC_RESET: begin
              base_d   = 1'b0;
              tick_d   = '0;
              push_o   = 1'b1;
              cmd_o.op = CMD_CLEAR;
            end
            default: ;
          endcase
        end
      end
      FE_SCAN: begin
        // Push a changed channel when the queue has room, skip an unchanged one
        if (mask_q[idx_q]) begin
          if (!full_i) begin
            push_o = 1'b1;
            step   = 1'b1;
          end
        end else begin
          step = 1'b1;
        end
        if (step) begin
          if (idx_q == ChanW'(ChannelCount - 1)) begin
            state_d = FE_IDLE;
          end else begin
            idx_d = idx_q + ChanW'(1);
          end
        end
      end
      default: state_d = FE_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FE_IDLE;
      tick_q  <= '0;
      base_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      tick_q  <= tick_d;
      base_q  <= base_d;
    end
  end

  // Sample and scan registers
  always_ff @(posedge clk_i) begin
    last_q   <= last_d;
    before_q <= before_d;
    after_q  <= after_d;
    mask_q   <= mask_d;
    idx_q    <= idx_d;
  end

endmodule

FILE: design/octr_fifo.sv
// Short command queue between the front and the back.
module octr_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  octr_pkg::octr_cmd_t data_i,
  input  logic                pop_i,
  output logic                full_o,
  output logic                empty_o,
  output octr_pkg::octr_cmd_t data_o
);
  import octr_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  octr_cmd_t       slot_q [QueueDepth];
  logic [PtrW-1:0] wr_q, wr_d;
  logic [PtrW-1:0] rd_q, rd_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == CntW'(QueueDepth));
  assign empty_o = (count_q == '0);
  assign data_o  = slot_q[rd_q];

  // Advance pointers and the fill count
  always_comb begin
    wr_d    = wr_q;
    rd_d    = rd_q;
    count_d = count_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(QueueDepth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

  // Store a pushed command
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= data_i;
    end
  end

`include "output_change_trace_ring_unit_assert.svh"

  `OCTR_ASSERT_CLK(a_count_bound, clk_i, rst_ni, count_q <= CntW'(QueueDepth), "queue count over depth")
  `OCTR_ASSERT_NEVER(a_push_full, clk_i, rst_ni, push_i && full_o, "push into full queue")
  `OCTR_ASSERT_CLK(a_count_up, clk_i, rst_ni, (push_i && !pop_i) |=> (count_q == $past(count_q) + CntW'(1)), "queue count did not follow push")

endmodule

FILE: design/octr_back.sv
// Back end: ring memory, sequence and drop counters, pop result registers.
module octr_back #(
  parameter int unsigned RING_DEPTH = octr_pkg::RingDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  octr_pkg::octr_cmd_t cmd_i,
  input  logic                empty_i,
  output logic                pop_o,
  output logic                done_o,
  output logic                entry_valid_o,
  output logic [63:0]         sequence_number_o,
  output logic [63:0]         tick_number_o,
  output logic [5:0]          ctr_addr_o,
  output logic signed [16:0]  change_amount_o,
  output logic [15:0]         prior_value_o,
  output logic [15:0]         new_value_o,
  output logic [12:0]         entries_pending_o,
  output logic [31:0]         dropped_total_o
);
  import octr_pkg::*;

  localparam int unsigned PtrW  = $clog2(RING_DEPTH);
  localparam int unsigned LiveW = $clog2(RING_DEPTH + 1);
  localparam int unsigned SumW  = LiveW + 1;

  octr_bk_state_e  state_q, state_d;
  logic [63:0]     seq_q, seq_d;
  logic [PtrW-1:0] wp_q, wp_d;
  logic [LiveW-1:0] live_q, live_d;
  logic [31:0]     drop_q, drop_d;
  logic            done_q;
  logic            mem_we;
  logic [PtrW-1:0] mem_addr;
  octr_entry_t     mem_wdata;
  octr_entry_t     ring_mem_q [RING_DEPTH];
  octr_entry_t     rdata_q;
  logic [PtrW-1:0] tail;
  logic [SumW-1:0] wp_ext;
  logic [SumW-1:0] live_ext;
  logic            load_empty;
  logic            load_entry;

  logic            entry_valid_q;
  logic [63:0]     seq_out_q;
  logic [63:0]     tick_out_q;
  logic [5:0]      addr_out_q;
  logic signed [16:0] change_out_q;
  logic [15:0]     before_out_q;
  logic [15:0]     after_out_q;
  logic [PendW-1:0] pending_out_q;
  logic [31:0]     dropped_out_q;

  // Oldest entry sits live entries behind the write pointer
  assign wp_ext   = SumW'(wp_q);
  assign live_ext = SumW'(live_q);
  assign tail = (wp_ext >= live_ext) ? PtrW'(wp_ext - live_ext)
                                     : PtrW'(wp_ext + SumW'(RING_DEPTH) - live_ext);

  // Execute one queued command
  always_comb begin
    state_d    = state_q;
    seq_d      = seq_q;
    wp_d       = wp_q;
    live_d     = live_q;
    drop_d     = drop_q;
    pop_o      = 1'b0;
    mem_we     = 1'b0;
    mem_addr   = wp_q;
    load_empty = 1'b0;
    load_entry = 1'b0;
    mem_wdata.seq    = seq_q + 64'd1;
    mem_wdata.tick   = cmd_i.tick;
    mem_wdata.chan   = cmd_i.chan;
    mem_wdata.prior  = cmd_i.prior;
    mem_wdata.after  = cmd_i.after;
    case (state_q)
      BK_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          case (cmd_i.op)
            CMD_PUSH: begin
              mem_we = 1'b1;
              seq_d  = seq_q + 64'd1;
              wp_d   = (wp_q == PtrW'(RING_DEPTH - 1)) ? '0 : wp_q + PtrW'(1);
              if (live_q < LiveW'(RING_DEPTH)) begin
                live_d = live_q + LiveW'(1);
              end else if (drop_q != '1) begin
                drop_d = drop_q + 32'd1;
              end
            end
            CMD_POP: begin
              if (live_q == '0) begin
                load_empty = 1'b1;
              end else begin
                mem_addr = tail;
                live_d   = live_q - LiveW'(1);
                state_d  = BK_READ;
              end
            end
            CMD_CLEAR: begin
              seq_d  = '0;
              wp_d   = '0;
              live_d = '0;
              drop_d = '0;
            end
            default: ;
          endcase
        end
      end
      BK_READ: begin
        load_entry = 1'b1;
        state_d    = BK_IDLE;
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      seq_q   <= '0;
      wp_q    <= '0;
      live_q  <= '0;
      drop_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      seq_q   <= seq_d;
      wp_q    <= wp_d;
      live_q  <= live_d;
      drop_q  <= drop_d;
      done_q  <= load_empty || load_entry;
    end
  end

  // Single-port ring memory, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ring_mem_q[mem_addr] <= mem_wdata;
    end
    rdata_q <= ring_mem_q[mem_addr];
  end

  // Load the result registers
  always_ff @(posedge clk_i) begin
    if (load_empty) begin
      entry_valid_q <= 1'b0;
      seq_out_q     <= '0;
      tick_out_q    <= '0;
      addr_out_q    <= '0;
      change_out_q  <= '0;
      before_out_q  <= '0;
      after_out_q   <= '0;
      pending_out_q <= '0;
      dropped_out_q <= drop_q;
    end else if (load_entry) begin
      entry_valid_q <= 1'b1;
      seq_out_q     <= rdata_q.seq;
      tick_out_q    <= rdata_q.tick;
      addr_out_q    <= chan_addr(rdata_q.chan);
      change_out_q  <= signed'(17'(rdata_q.after) - 17'(rdata_q.prior));
      before_out_q  <= 16'(rdata_q.prior);
      after_out_q   <= 16'(rdata_q.after);
      pending_out_q <= PendW'(live_q);
      dropped_out_q <= drop_q;
    end
  end

  assign done_o            = done_q;
  assign entry_valid_o     = entry_valid_q;
  assign sequence_number_o = seq_out_q;
  assign tick_number_o     = tick_out_q;
  assign ctr_addr_o        = addr_out_q;
  assign change_amount_o   = change_out_q;
  assign prior_value_o     = before_out_q;
  assign new_value_o       = after_out_q;
  assign entries_pending_o = pending_out_q;
  assign dropped_total_o   = dropped_out_q;

`include "output_change_trace_ring_unit_assert.svh"

  `OCTR_ASSERT_CLK(a_live_bound, clk_i, rst_ni, live_q <= LiveW'(RING_DEPTH), "live count over ring depth")
  `OCTR_ASSERT_CLK(a_wp_bound, clk_i, rst_ni, wp_q <= PtrW'(RING_DEPTH - 1), "write pointer out of range")
  `OCTR_ASSERT_CLK(a_read_done, clk_i, rst_ni, (state_q == BK_READ) |=> done_o, "ring read gave no result")
  `OCTR_ASSERT_NEVER(a_pop_empty, clk_i, rst_ni, pop_o && empty_i, "dequeue from empty queue")

endmodule
